>>> hw/rtl/wocet_pkg.sv
package wocet_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 4;

  localparam logic [ThrW-1:0]   OpenThrRst = ThrW'(1000);
  localparam logic [TimeW-1:0]  MinDurRst  = TimeW'(20000);
  localparam logic [TimeW-1:0]  MaxDurRst  = TimeW'(60000);
  localparam logic [CountW-1:0] CountMax   = '1;

  typedef enum logic [1:0] {
    RegOpenThr = 2'd0,
    RegMinDur  = 2'd1,
    RegMaxDur  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      invert;
    logic [TimeW-1:0]          now_ms;
  } in_t;

  typedef struct packed {
    logic              is_open;
    logic [CountW-1:0] close_count;
    logic [TimeW-1:0]  start_ms;
    logic [TimeW-1:0]  end_ms;
    logic [TimeW-1:0]  duration_ms;
    logic              upgrade_trigger;
  } out_t;

  typedef struct packed {
    logic [ThrW-1:0]  open_threshold;
    logic [TimeW-1:0] min_duration_ms;
    logic [TimeW-1:0] max_duration_ms;
  } cfg_t;

endpackage

>>> hw/rtl/wocet_stream_if.sv
interface wocet_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/wocet_cfg.sv
module wocet_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wocet_pkg::AddrW-1:0] paddr,
  input  logic [wocet_pkg::DataW-1:0] pwdata,
  output logic [wocet_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output wocet_pkg::cfg_t            cfg_o
);
  import wocet_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_threshold  <= OpenThrRst;
      cfg_q.min_duration_ms <= MinDurRst;
      cfg_q.max_duration_ms <= MaxDurRst;
    end else if (wr_en) begin
      unique case (idx)
        RegOpenThr: cfg_q.open_threshold  <= pwdata[ThrW-1:0];
        RegMinDur:  cfg_q.min_duration_ms <= pwdata[TimeW-1:0];
        RegMaxDur:  cfg_q.max_duration_ms <= pwdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegOpenThr: prdata = DataW'(cfg_q.open_threshold);
      RegMinDur:  prdata = DataW'(cfg_q.min_duration_ms);
      RegMaxDur:  prdata = DataW'(cfg_q.max_duration_ms);
      default:    prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/wocet_in_stage.sv
module wocet_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  wocet_stream_if.sink   in_i,
  input  logic           take_i,
  output logic           valid_o,
  output wocet_pkg::in_t item_o
);
  import wocet_pkg::*;

  logic valid_q, valid_d;
  in_t  item_q;

  assign in_i.ready = !valid_q || take_i;
  assign valid_d    = in_i.ready ? in_i.valid : valid_q;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.payload;
    end
  end

endmodule

>>> hw/rtl/wocet_eval.sv
module wocet_eval (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wocet_pkg::cfg_t cfg_i,
  input  logic            valid_i,
  input  wocet_pkg::in_t  item_i,
  output logic            take_o,
  wocet_stream_if.source  out_o
);
  import wocet_pkg::*;

  logic              prev_open_q, prev_open_d;
  logic [CountW-1:0] count_q, count_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic              start_vld_q;
  logic [TimeW-1:0]  end_q, end_d;
  logic              end_vld_q, end_vld_d;
  logic [TimeW-1:0]  len_q, len_d;
  logic              first_q, first_d;
  logic              cal_q, cal_d;
  logic              out_vld_q, out_vld_d;
  out_t              out_q, out_d;

  logic [SampleW:0] mag;
  logic             is_open;
  logic             prev_eff;
  logic             edge_hit;
  logic [CountW-1:0] want;
  logic             in_win;

  assign take_o = valid_i && (!out_vld_q || out_o.ready);

  always_comb begin
    mag = item_i.sample[SampleW-1]
        ? ((SampleW+1)'(1) << SampleW) - {1'b0, item_i.sample}
        : {1'b0, item_i.sample};
    is_open  = (mag < {1'b0, cfg_i.open_threshold}) ^ item_i.invert;
    prev_eff = (cal_q && item_i.invert) ? 1'b1 : prev_open_q;
    cal_d    = cal_q && !item_i.invert;
    edge_hit = is_open != prev_eff;

    count_d = count_q;
    if (edge_hit && !is_open && count_q != CountMax) begin
      count_d = count_q + CountW'(1);
    end

    start_d   = (edge_hit && end_vld_q) ? end_q : start_q;
    end_vld_d = end_vld_q && !edge_hit;
    if (!start_vld_q) begin
      start_d = item_i.now_ms;
    end

    end_d = end_q;
    len_d = len_q;
    if (edge_hit) begin
      end_d     = item_i.now_ms;
      end_vld_d = 1'b1;
      len_d     = item_i.now_ms - start_d;
    end

    want    = item_i.invert ? CountW'(2) : CountW'(1);
    in_win  = (len_d >= cfg_i.min_duration_ms) && (len_d <= cfg_i.max_duration_ms);
    first_d = first_q && (count_d != CountW'(1));
    prev_open_d = is_open;

    out_d.is_open         = is_open;
    out_d.close_count     = count_d;
    out_d.start_ms        = start_d;
    out_d.end_ms          = end_d;
    out_d.duration_ms     = len_d;
    out_d.upgrade_trigger = edge_hit && !first_q && (count_d == want) && in_win;

    out_vld_d = take_o ? edge_hit : (out_vld_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_open_q <= 1'b0;
      count_q     <= '0;
      start_q     <= '0;
      start_vld_q <= 1'b0;
      end_q       <= '0;
      end_vld_q   <= 1'b0;
      len_q       <= '0;
      first_q     <= 1'b1;
      cal_q       <= 1'b1;
      out_vld_q   <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (take_o) begin
        prev_open_q <= prev_open_d;
        count_q     <= count_d;
        start_q     <= start_d;
        start_vld_q <= 1'b1;
        end_q       <= end_d;
        end_vld_q   <= end_vld_d;
        len_q       <= len_d;
        first_q     <= first_d;
        cal_q       <= cal_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && edge_hit) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

endmodule

>>> hw/rtl/window_open_close_event_timer_unit.sv
// Window open/close event timer.
// in_i carries one sensor transaction: signed sample, invert flag and a
// millisecond timestamp. out_o carries one report per open/closed edge:
// new state, saturating close count, interval start/end, duration and the
// upgrade trigger. Samples that cause no edge produce no report.
// Both channels use valid/ready; a transaction moves when both are high.
// Path: an accepted sample lands in the input register; the evaluation
// logic takes it from there and loads the result register, which offers
// the report. A stalled receiver can hold the sample between the two.
// Throughput: one sample per cycle while the receiver does not stall; the
// evaluation stage updates its state once per sample it takes.
// If the receiver stalls, the pending report is held; one more sample waits
// in the input register and further samples are refused until it drains.
// Reset clears all tracking state, sets open_threshold to 1000 and the
// duration limits to 20000 and 60000 ms, and empties both registers. The
// APB port writes open_threshold, min_duration_ms and max_duration_ms at
// byte offsets 0, 4 and 8; write it only while no transaction is in flight.
module window_open_close_event_timer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  wocet_stream_if.sink                in_i,
  wocet_stream_if.source              out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wocet_pkg::AddrW-1:0] paddr,
  input  logic [wocet_pkg::DataW-1:0] pwdata,
  output logic [wocet_pkg::DataW-1:0] prdata,
  output logic                        pready
);
  import wocet_pkg::*;

  cfg_t cfg;
  logic take;
  logic stage_vld;
  in_t  stage_item;

  wocet_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wocet_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (stage_vld),
    .item_o  (stage_item)
  );

  wocet_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (stage_vld),
    .item_i  (stage_item),
    .take_o  (take),
    .out_o   (out_o)
  );

endmodule
